/* hw/rtl/multi_format_packet_header_parser_macros.svh */
// ----------------------------------------------------------------------------
// Packet header parser assertion macros
// Concurrent assertion wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTI_FORMAT_PACKET_HEADER_PARSER_MACROS_SVH
`define MULTI_FORMAT_PACKET_HEADER_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define MFP_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define MFP_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define MFP_ASSERT_IMP(lbl, clk, rst_n, a, c, msg)
`define MFP_ASSERT_NXT(lbl, clk, rst_n, a, c, msg)
`endif
`endif

/* hw/rtl/mfphp_pkg.sv */
// ----------------------------------------------------------------------------
// Packet header parser package
// Format and field tables, result and command types.
// ----------------------------------------------------------------------------
package mfphp_pkg;

  localparam int unsigned NumFormats = 11;
  localparam int unsigned HdrDepth   = 17;
  localparam int unsigned NumFields  = 44;
  localparam int unsigned PreLong    = 986;
  localparam int unsigned PreShort   = 13;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_FIELD   = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_SIZE      = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CTL_STREAM,
    CTL_FIELDS,
    CTL_STATUS
  } ctl_state_t;

  typedef struct packed {
    logic [9:0] fixed;
    logic [9:0] hstart;
    logic [9:0] hend;
    logic [2:0] depth;
    logic       payload;
    logic [5:0] first;
    logic [3:0] nf;
  } fmt_desc_t;

  typedef struct packed {
    logic [4:0] id;
    logic [4:0] off;
    logic [2:0] len;
    logic       dly;
  } fld_desc_t;

  typedef struct packed {
    logic       byte_go;
    logic       fld_go;
    logic [3:0] fld_idx;
    logic       sts_go;
  } dp_cmd_t;

  typedef struct packed {
    logic       eop;
    logic       pay_out;
    logic       st_ok;
    logic [3:0] nf;
  } dp_sts_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [4:0]  field_id;
    logic [31:0] field_value;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic        last_result;
  } res_t;

  typedef struct packed {
    logic [3:0] format;
    logic [7:0] data_byte;
    logic       end_of_packet;
  } item_t;

  function automatic fmt_desc_t fmt_lookup(input logic [3:0] f);
    fmt_desc_t d;
    d = '{fixed: 10'd8, hstart: 10'd0, hend: 10'd8, depth: 3'd0, payload: 1'b0,
          first: 6'd0, nf: 4'd3};
    unique case (f)
      4'd1:  d = '{10'd12, 10'd0, 10'd12, 3'd0, 1'b0, 6'd3, 4'd6};
      4'd2:  d = '{10'd8, 10'd0, 10'd8, 3'd0, 1'b1, 6'd9, 4'd4};
      4'd3:  d = '{10'd17, 10'd0, 10'd17, 3'd0, 1'b1, 6'd13, 4'd9};
      4'd4:  d = '{10'd8, 10'd0, 10'd8, 3'd0, 1'b0, 6'd22, 4'd3};
      4'd5:  d = '{10'd7, 10'd0, 10'd6, 3'd1, 1'b1, 6'd25, 4'd3};
      4'd6:  d = '{10'd996, 10'(PreLong), 10'(PreLong + 6), 3'd4, 1'b1, 6'd28, 4'd4};
      4'd7:  d = '{10'd23, 10'(PreShort), 10'(PreShort + 6), 3'd4, 1'b1, 6'd32, 4'd4};
      4'd8:  d = '{10'd11, 10'd0, 10'd11, 3'd0, 1'b0, 6'd36, 4'd5};
      4'd9:  d = '{10'd6, 10'd0, 10'd6, 3'd0, 1'b0, 6'd41, 4'd2};
      4'd10: d = '{10'd3, 10'd0, 10'd3, 3'd0, 1'b0, 6'd43, 4'd1};
      default: d = d;
    endcase
    return d;
  endfunction

  function automatic fld_desc_t fld_lookup(input logic [5:0] i);
    fld_desc_t d;
    unique case (i)
      6'd0:  d = '{5'd0, 5'd0, 3'd3, 1'b0};
      6'd1:  d = '{5'd1, 5'd3, 3'd3, 1'b0};
      6'd2:  d = '{5'd2, 5'd6, 3'd2, 1'b0};
      6'd3:  d = '{5'd3, 5'd0, 3'd1, 1'b0};
      6'd4:  d = '{5'd4, 5'd1, 3'd3, 1'b0};
      6'd5:  d = '{5'd5, 5'd4, 3'd1, 1'b0};
      6'd6:  d = '{5'd6, 5'd5, 3'd1, 1'b0};
      6'd7:  d = '{5'd7, 5'd6, 3'd2, 1'b0};
      6'd8:  d = '{5'd8, 5'd8, 3'd4, 1'b0};
      6'd9:  d = '{5'd0, 5'd0, 3'd3, 1'b0};
      6'd10: d = '{5'd9, 5'd3, 3'd1, 1'b0};
      6'd11: d = '{5'd1, 5'd4, 3'd3, 1'b0};
      6'd12: d = '{5'd3, 5'd7, 3'd1, 1'b0};
      6'd13: d = '{5'd10, 5'd0, 3'd4, 1'b0};
      6'd14: d = '{5'd11, 5'd4, 3'd3, 1'b0};
      6'd15: d = '{5'd12, 5'd7, 3'd1, 1'b0};
      6'd16: d = '{5'd13, 5'd8, 3'd1, 1'b0};
      6'd17: d = '{5'd14, 5'd9, 3'd1, 1'b0};
      6'd18: d = '{5'd15, 5'd10, 3'd1, 1'b0};
      6'd19: d = '{5'd0, 5'd11, 3'd3, 1'b0};
      6'd20: d = '{5'd16, 5'd14, 3'd2, 1'b0};
      6'd21: d = '{5'd17, 5'd16, 3'd1, 1'b0};
      6'd22: d = '{5'd0, 5'd0, 3'd3, 1'b0};
      6'd23: d = '{5'd1, 5'd3, 3'd3, 1'b0};
      6'd24: d = '{5'd2, 5'd6, 3'd2, 1'b0};
      6'd25: d = '{5'd0, 5'd0, 3'd3, 1'b0};
      6'd26: d = '{5'd1, 5'd3, 3'd3, 1'b0};
      6'd27: d = '{5'd18, 5'd0, 3'd1, 1'b1};
      6'd28: d = '{5'd19, 5'd0, 3'd2, 1'b0};
      6'd29: d = '{5'd20, 5'd2, 3'd2, 1'b0};
      6'd30: d = '{5'd21, 5'd4, 3'd2, 1'b0};
      6'd31: d = '{5'd22, 5'd0, 3'd4, 1'b1};
      6'd32: d = '{5'd19, 5'd0, 3'd2, 1'b0};
      6'd33: d = '{5'd20, 5'd2, 3'd2, 1'b0};
      6'd34: d = '{5'd21, 5'd4, 3'd2, 1'b0};
      6'd35: d = '{5'd22, 5'd0, 3'd4, 1'b1};
      6'd36: d = '{5'd4, 5'd0, 3'd3, 1'b0};
      6'd37: d = '{5'd5, 5'd3, 3'd1, 1'b0};
      6'd38: d = '{5'd6, 5'd4, 3'd1, 1'b0};
      6'd39: d = '{5'd7, 5'd5, 3'd2, 1'b0};
      6'd40: d = '{5'd8, 5'd7, 3'd4, 1'b0};
      6'd41: d = '{5'd23, 5'd0, 3'd2, 1'b0};
      6'd42: d = '{5'd24, 5'd2, 3'd4, 1'b0};
      default: d = '{5'd0, 5'd0, 3'd3, 1'b0};
    endcase
    return d;
  endfunction

endpackage

/* hw/rtl/mfphp_if.sv */
// ----------------------------------------------------------------------------
// Packet header parser channels
// Valid/ready channel interfaces for input bytes and results.
// ----------------------------------------------------------------------------
interface mfphp_in_if;
  logic                 valid;
  logic                 ready;
  mfphp_pkg::item_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mfphp_out_if;
  logic                 valid;
  logic                 ready;
  mfphp_pkg::res_t      data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/mfphp_ctrl.sv */
// ----------------------------------------------------------------------------
// Packet header parser controller
// Sequences byte intake, header field emission and end status.
// ----------------------------------------------------------------------------
`include "multi_format_packet_header_parser_macros.svh"
module mfphp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_busy,
  input  mfphp_pkg::dp_sts_t sts,
  output mfphp_pkg::dp_cmd_t cmd
);
  import mfphp_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_STREAM;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_ready  = 1'b0;
    cmd.fld_idx = idx_r;
    unique case (state_r)
      CTL_STREAM: begin
        in_ready    = !out_busy;
        cmd.byte_go = in_valid && !out_busy;
        if (cmd.byte_go && sts.eop) begin
          idx_nxt   = '0;
          state_nxt = sts.st_ok ? CTL_FIELDS : CTL_STATUS;
          if (sts.pay_out) begin
            // payload result goes first; any fields and the end status follow
          end
        end
      end
      CTL_FIELDS: begin
        if (!out_busy) begin
          cmd.fld_go = 1'b1;
          idx_nxt    = idx_r + 4'd1;
          if (idx_r + 4'd1 == sts.nf) state_nxt = CTL_STATUS;
        end
      end
      CTL_STATUS: begin
        if (!out_busy) begin
          cmd.sts_go = 1'b1;
          state_nxt  = CTL_STREAM;
        end
      end
      default: state_nxt = CTL_STREAM;
    endcase
  end

  `MFP_ASSERT_IMP(a_no_take_busy, clk, rst_n, in_ready, !out_busy, "input taken while output full")
  `MFP_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.byte_go, cmd.fld_go, cmd.sts_go}), "multiple commands")
  `MFP_ASSERT_NXT(a_sts_back, clk, rst_n, cmd.sts_go, state_r == CTL_STREAM, "status not followed by stream")
endmodule

/* hw/rtl/mfphp_dp.sv */
// ----------------------------------------------------------------------------
// Packet header parser datapath
// Byte counter, header store, trailer delay and result register.
// ----------------------------------------------------------------------------
module mfphp_dp #(
  parameter int unsigned MAX_PACKET_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mfphp_pkg::item_t   in_item,
  input  mfphp_pkg::dp_cmd_t cmd,
  output mfphp_pkg::dp_sts_t sts,
  output logic               out_busy,
  output logic               out_valid,
  input  logic               out_ready,
  output mfphp_pkg::res_t    out_res
);
  import mfphp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PACKET_BYTES + 1);

  logic [CW-1:0] cnt_r;
  logic [3:0]    fmt_r;
  logic          ovf_r;
  logic [7:0]    hdr_r [HdrDepth];
  logic [7:0]    dly_r [4];
  logic [1:0]    st_r;
  logic          vld_r;
  res_t          res_r;

  logic [3:0]    fmt_c;
  fmt_desc_t     fd, fdr;
  logic          known, inr;
  logic [CW-1:0] cnt_n;
  logic [CW-1:0] pos;
  logic [CW-1:0] kidx;
  logic          in_hdr, in_pay, emit_pay;
  logic [1:0]    st_c;
  fld_desc_t     fl;
  logic [31:0]   fval;
  logic [7:0]    pb;

  assign fmt_c  = (cnt_r == '0) ? in_item.format : fmt_r;
  assign known  = fmt_c < 4'(NumFormats);
  assign fd     = fmt_lookup(known ? fmt_c : 4'd0);
  assign inr    = cnt_r < CW'(MAX_PACKET_BYTES);
  assign cnt_n  = inr ? cnt_r + CW'(1) : cnt_r;
  assign in_hdr = known && inr && cnt_r >= CW'(fd.hstart) && cnt_r < CW'(fd.hend);
  assign in_pay = known && inr && cnt_r >= CW'(fd.hend) && fd.payload;
  assign pos    = cnt_r - CW'(fd.hend);
  assign kidx   = cnt_r - CW'(fd.hstart);
  assign emit_pay = in_pay && (fd.depth == 3'd0 || pos >= CW'(fd.depth));
  assign pb     = (fd.depth == 3'd0) ? in_item.data_byte : dly_r[0];

  always_comb begin
    if (!known) st_c = ST_UNKNOWN;
    else if (ovf_r || !inr) st_c = ST_SIZE;
    else if (!fd.payload && cnt_n != CW'(fd.fixed)) st_c = ST_SIZE;
    else if (fd.payload && cnt_n < CW'(fd.fixed)) st_c = ST_TRUNCATED;
    else st_c = ST_OK;
  end

  assign sts.eop     = in_item.end_of_packet;
  assign sts.pay_out = emit_pay;
  assign sts.st_ok   = st_c == ST_OK;
  assign fdr         = fmt_lookup(fmt_r < 4'(NumFormats) ? fmt_r : 4'd0);
  assign sts.nf      = fdr.nf;

  assign fl = fld_lookup(fdr.first + 6'(cmd.fld_idx));
  always_comb begin
    logic [4:0] p;
    fval = '0;
    for (int k = 0; k < 4; k++) begin
      p = fl.off + 5'(k);
      if (3'(k) < fl.len) fval = {fval[23:0],
        fl.dly ? dly_r[p[1:0]] : hdr_r[(p < 5'(HdrDepth)) ? p : p - 5'(HdrDepth)]};
    end
  end

  assign out_busy  = vld_r && !out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      fmt_r <= '0;
      ovf_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      vld_r <= (vld_r && !out_ready) || (cmd.byte_go && emit_pay) ||
               cmd.fld_go || cmd.sts_go;
      if (cmd.byte_go) begin
        fmt_r <= fmt_c;
        if (in_item.end_of_packet) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          cnt_r <= cnt_n;
          ovf_r <= ovf_r || !inr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_go) begin
      st_r <= st_c;
      if (in_hdr && kidx < CW'(HdrDepth)) hdr_r[kidx[4:0]] <= in_item.data_byte;
      if (in_pay && fd.depth != 3'd0) begin
        if (pos >= CW'(fd.depth)) begin
          if (fd.depth == 3'd4) begin
            dly_r[0] <= dly_r[1];
            dly_r[1] <= dly_r[2];
            dly_r[2] <= dly_r[3];
            dly_r[3] <= in_item.data_byte;
          end else begin
            dly_r[0] <= in_item.data_byte;
          end
        end else begin
          dly_r[pos[1:0]] <= in_item.data_byte;
        end
      end
      res_r <= '{KIND_PAYLOAD, 5'd0, 32'd0, pb, ST_OK, !in_item.end_of_packet};
    end
    if (cmd.fld_go) res_r <= '{KIND_FIELD, fl.id, fval, 8'd0, ST_OK, 1'b0};
    if (cmd.sts_go) res_r <= '{KIND_STATUS, 5'd0, 32'd0, 8'd0, st_r, 1'b1};
  end
endmodule

/* hw/rtl/multi_format_packet_header_parser.sv */
// Payload: a result holding the taken byte, or for trailer formats the oldest
// delayed byte, is registered. Throughput: one byte per cycle within a packet
// while the output is free; intake pauses after the end byte while fields (on
// OK status) and the end status go out, and while a result is held unread.
// Reset: synchronous active-low rst_n clears counters, format and control.
// ----------------------------------------------------------------------------
// Multi-format packet header parser
// Parses packet bytes into header fields, payload bytes and an end status.
// ----------------------------------------------------------------------------
module multi_format_packet_header_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 4096
) (
  input logic         clk,
  input logic         rst_n,
  mfphp_in_if.sink    in_ch,
  mfphp_out_if.source out_ch
);
  import mfphp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    out_busy;

  mfphp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_busy(out_busy), .sts(sts), .cmd(cmd)
  );

  mfphp_dp #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_ch.data), .cmd(cmd), .sts(sts),
    .out_busy(out_busy), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_res(out_ch.data)
  );
endmodule

/* bench/multi_format_packet_header_parser_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet header parser testbench
// Streams packets of every format but the long OTA one through the parser:
// exact sizes, wrong and truncated sizes, unknown codes and random traffic.
// A behavioral model predicts payload bytes, header fields and end status;
// each result transaction is checked in order against it.
// ----------------------------------------------------------------------------
module multi_format_packet_header_parser_test;
  import mfphp_pkg::*;

  localparam int MaxBytes = 4096;
  localparam int NumFmt   = 11;

  typedef enum logic [3:0] {
    FMT_ACK, FMT_HELLO, FMT_HOP, FMT_MAC, FMT_MAC_HOP, FMT_NETWORK,
    FMT_OTA_LONG, FMT_OTA_SHORT, FMT_ROUTES, FMT_SNMP, FMT_SENT_INFO,
    FMT_UNKNOWN, FMT_MAX = 4'd15
  } fmt_e;

  localparam int FixedLen[NumFmt] = '{8, 12, 8, 17, 8, 7, 996, 23, 11, 6, 3};
  localparam int HdrStart[NumFmt] = '{0, 0, 0, 0, 0, 0, 986, 13, 0, 0, 0};
  localparam int HdrEnd[NumFmt]   = '{8, 12, 8, 17, 8, 6, 992, 19, 11, 6, 3};
  localparam int TrlDepth[NumFmt] = '{0, 0, 0, 0, 0, 1, 4, 4, 0, 0, 0};
  localparam bit HasPay[NumFmt]   = '{0, 0, 1, 1, 0, 1, 1, 1, 0, 0, 0};
  localparam int FirstFld[NumFmt] = '{0, 3, 9, 13, 22, 25, 28, 32, 36, 41, 43};
  localparam int NumFld[NumFmt]   = '{3, 6, 4, 9, 3, 3, 4, 4, 5, 2, 1};

  localparam int FldId[44] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 0, 9, 1, 3, 10, 11, 12, 13,
    14, 15, 0, 16, 17, 0, 1, 2, 0, 1, 18, 19, 20, 21, 22, 19, 20, 21, 22, 4, 5, 6, 7,
    8, 23, 24, 0};
  localparam int FldOff[44] = '{0, 3, 6, 0, 1, 4, 5, 6, 8, 0, 3, 4, 7, 0, 4, 7, 8,
    9, 10, 11, 14, 16, 0, 3, 6, 0, 3, 0, 0, 2, 4, 0, 0, 2, 4, 0, 0, 3, 4, 5, 7, 0,
    2, 0};
  localparam int FldLen[44] = '{3, 3, 2, 1, 3, 1, 1, 2, 4, 3, 1, 3, 1, 4, 3, 1, 1,
    1, 1, 3, 2, 1, 3, 3, 2, 3, 3, 1, 2, 2, 2, 4, 2, 2, 2, 4, 3, 1, 1, 2, 4, 2, 4, 3};
  localparam bit FldTrl[44] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0};

  logic clk = 1'b0;
  logic rst_n;

  mfphp_in_if  in_ch ();
  mfphp_out_if out_ch ();

  multi_format_packet_header_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // parser model state
  int         pkt_count;
  logic [3:0] pkt_fmt;
  logic [7:0] hdr_bytes[17];
  logic [7:0] trl_bytes[4];
  bit         too_long;

  res_t expected_results[$];
  int   failures;
  int   in_idle_pct;
  int   out_idle_pct;
  int   hold_cycles;

  function automatic res_t blank_result();
    res_t r;
    r = '0;
    return r;
  endfunction

  function automatic void predict_byte(item_t it);
    res_t       batch[$];
    res_t       r;
    bit         known;
    int         f;
    int         i;
    int         pos;
    status_t    st;
    logic [31:0] v;
    if (pkt_count == 0) pkt_fmt = it.format;
    known = pkt_fmt < NumFmt;
    f = known ? int'(pkt_fmt) : 0;
    if (pkt_count >= MaxBytes) begin
      too_long = 1'b1;
    end else begin
      i = pkt_count;
      pkt_count++;
      if (known && i >= HdrStart[f]) begin
        if (i < HdrEnd[f]) begin
          if (i - HdrStart[f] < 17) hdr_bytes[i - HdrStart[f]] = it.data_byte;
        end else if (HasPay[f]) begin
          pos = i - HdrEnd[f];
          r = blank_result();
          r.result_kind = KIND_PAYLOAD;
          if (TrlDepth[f] == 0) begin
            r.payload_byte = it.data_byte;
            batch = {batch, r};
          end else if (pos >= TrlDepth[f]) begin
            r.payload_byte = trl_bytes[0];
            batch = {batch, r};
            for (int j = 0; j < TrlDepth[f] - 1; j++) trl_bytes[j] = trl_bytes[j + 1];
            trl_bytes[TrlDepth[f] - 1] = it.data_byte;
          end else begin
            trl_bytes[pos] = it.data_byte;
          end
        end
      end
    end
    if (it.end_of_packet) begin
      if (!known) st = ST_UNKNOWN;
      else if (too_long) st = ST_SIZE;
      else if (!HasPay[f] && pkt_count != FixedLen[f]) st = ST_SIZE;
      else if (HasPay[f] && pkt_count < FixedLen[f]) st = ST_TRUNCATED;
      else st = ST_OK;
      if (st == ST_OK) begin
        for (int e = FirstFld[f]; e < FirstFld[f] + NumFld[f]; e++) begin
          v = '0;
          for (int k = 0; k < FldLen[e]; k++)
            v = {v[23:0], FldTrl[e] ? trl_bytes[(FldOff[e] + k) % 4]
                                    : hdr_bytes[(FldOff[e] + k) % 17]};
          r = blank_result();
          r.result_kind = KIND_FIELD;
          r.field_id = 5'(FldId[e]);
          r.field_value = v;
          batch = {batch, r};
        end
      end
      r = blank_result();
      r.result_kind = KIND_STATUS;
      r.status = st;
      batch = {batch, r};
      pkt_count = 0;
      too_long = 1'b0;
    end
    if (batch.size() > 0) batch[batch.size() - 1].last_result = 1'b1;
    expected_results = {expected_results, batch};
  endfunction

  task automatic send_byte(logic [3:0] fmt, logic [7:0] b, logic eop);
    item_t it;
    it = '{format: fmt, data_byte: b, end_of_packet: eop};
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= item_t'(13'($urandom));
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(it);
  endtask

  // fill < 0: random bytes; later bytes carry a random format code
  task automatic send_packet(logic [3:0] fmt, int len, int fill);
    for (int j = 0; j < len; j++)
      send_byte(j == 0 ? fmt : 4'($urandom_range(15)),
                fill < 0 ? 8'($urandom_range(255)) : 8'(fill), j == len - 1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_exact_formats();
    for (int f = 0; f < NumFmt; f++)
      if (f != FMT_OTA_LONG) send_packet(4'(f), FixedLen[f], (f % 2) ? 255 : 0);
    send_packet(FMT_OTA_SHORT, 26, -1);
  endtask

  task automatic test_bad_sizes();
    send_packet(FMT_UNKNOWN, 2, -1);
    send_packet(FMT_MAX, 1, 255);
    send_packet(FMT_ACK, 5, -1);
    send_packet(FMT_SNMP, 7, -1);
    send_packet(FMT_HOP, 5, -1);
    send_packet(FMT_NETWORK, 6, -1);
    send_packet(FMT_OTA_SHORT, 3, -1);
    send_packet(FMT_SENT_INFO, 1, 0);
  endtask

  task automatic test_random(int n_items);
    int sent;
    int f;
    int len;
    sent = 0;
    while (sent < n_items) begin
      f = $urandom_range(NumFmt - 1);
      if (f == FMT_OTA_LONG) f = FMT_OTA_SHORT;
      len = FixedLen[f];
      if ($urandom_range(9) == 0) f = $urandom_range(NumFmt, 15);
      else if ($urandom_range(4) == 0) len = $urandom_range(1, len + 3);
      else if (HasPay[f]) len += $urandom_range(6);
      send_packet(4'(f), len, -1);
      sent += len;
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 150;
    send_packet(FMT_HOP, 12, -1);
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction %h", got);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (got.result_kind !== want.result_kind) begin
          $error("result_kind exp %0d got %0d", want.result_kind, got.result_kind);
          failures++;
        end
        if (got.field_id !== want.field_id) begin
          $error("field_id exp %0d got %0d", want.field_id, got.field_id);
          failures++;
        end
        if (got.field_value !== want.field_value) begin
          $error("field_value exp %h got %h", want.field_value, got.field_value);
          failures++;
        end
        if (got.payload_byte !== want.payload_byte) begin
          $error("payload_byte exp %h got %h", want.payload_byte, got.payload_byte);
          failures++;
        end
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status);
          failures++;
        end
        if (got.last_result !== want.last_result) begin
          $error("last_result exp %0d got %0d", want.last_result, got.last_result);
          failures++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    failures = 0;
    hold_cycles = 0;
    pkt_count = 0;
    pkt_fmt = '0;
    too_long = 1'b0;
    in_idle_pct = 25;
    out_idle_pct = 74;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_exact_formats();
    test_bad_sizes();
    drain();

    in_idle_pct = 74;
    out_idle_pct = 25;
    test_backpressure();
    test_random(6);
    drain();

    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random(6);
    drain();
    repeat (20) @(posedge clk);

    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mfphp_pkg.sv
hw/rtl/mfphp_if.sv
hw/rtl/mfphp_ctrl.sv
hw/rtl/mfphp_dp.sv
hw/rtl/multi_format_packet_header_parser.sv
bench/multi_format_packet_header_parser_test.sv
